// ===== rtl/core/mbps_pkg.sv =====
`timescale 1ns / 1ps

package mbps_pkg;

  // Default sizes
  localparam int PAT_MAX_DEF     = 16;
  localparam int OFFSET_BITS_DEF = 32;

  // Fixed field widths
  localparam int PAT_BYTES_MAX = 16;
  localparam int LEN_W         = 5;
  localparam int CARE_W        = 16;
  localparam int LIMIT_W       = 16;
  localparam int COUNT_W       = 16;
  localparam int OUT_OFF_W     = 32;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 64;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAT_LOW  = 3'd0,
    CFG_PAT_HIGH = 3'd1,
    CFG_CARE     = 3'd2,
    CFG_LENGTH   = 3'd3,
    CFG_LIMIT    = 3'd4
  } cfg_idx_t;

  // One result beat
  typedef struct packed {
    logic                 match_found;
    logic [OUT_OFF_W-1:0] match_offset;
    logic                 limit_reached;
    logic                 scan_done;
  } result_t;

endpackage

// ===== rtl/core/mbps_in_if.sv =====
`timescale 1ns / 1ps

interface mbps_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       region_start;
  logic       region_end;

  modport source (output valid, output data_byte, output region_start, output region_end,
                  input ready);
  modport sink (input valid, input data_byte, input region_start, input region_end,
                output ready);
endinterface

// ===== rtl/core/mbps_out_if.sv =====
`timescale 1ns / 1ps

interface mbps_out_if;
  logic                            valid;
  logic                            ready;
  logic                            match_found;
  logic [mbps_pkg::OUT_OFF_W-1:0]  match_offset;
  logic                            limit_reached;
  logic                            scan_done;

  modport source (output valid, output match_found, output match_offset,
                  output limit_reached, output scan_done, input ready);
  modport sink (input valid, input match_found, input match_offset,
                input limit_reached, input scan_done, output ready);
endinterface

// ===== rtl/core/mbps_cfg_if.sv =====
`timescale 1ns / 1ps

interface mbps_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [mbps_pkg::CFG_IDX_W-1:0]   reg_index;
  logic [mbps_pkg::CFG_DATA_W-1:0]  wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink (input valid, input reg_index, input wr_data, output ready);
endinterface

// ===== rtl/core/masked_byte_pattern_scanner_unit.sv =====
`timescale 1ns / 1ps
// Each result is registered, in the skid entry if the output is stalled. Throughput:
// one byte per cycle while the skid entry is empty; all window compares run in parallel
// off the shift history. A two-entry output buffer (result register plus skid) keeps
// input flowing one beat into an output stall. Reset (rst_n low, synchronous) restores
// the configuration defaults and clears history, position, match count and the stop flag.
module masked_byte_pattern_scanner_unit #(
  parameter int PAT_MAX     = mbps_pkg::PAT_MAX_DEF,
  parameter int OFFSET_BITS = mbps_pkg::OFFSET_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  mbps_in_if.sink     in_beat,
  mbps_out_if.source  out_beat,
  mbps_cfg_if.sink    cfg_beat
);

  localparam int IDX_W = (PAT_MAX > 1) ? $clog2(PAT_MAX) : 1;
  localparam logic [mbps_pkg::LEN_W-1:0] PAT_MAX_L = mbps_pkg::LEN_W'(PAT_MAX);
  localparam logic [mbps_pkg::LEN_W-1:0] IDX_MASK  = mbps_pkg::LEN_W'(PAT_MAX - 1);
  localparam int PAT_BYTES_ALL_W = 8 * mbps_pkg::PAT_BYTES_MAX;

  // Configuration registers
  logic [63:0]                      pat_low_r, pat_high_r;
  logic [mbps_pkg::CARE_W-1:0]      care_r;
  logic [mbps_pkg::LEN_W-1:0]       len_r;
  logic [mbps_pkg::LIMIT_W-1:0]     limit_r;

  // Scan state
  logic [7:0]                       hist_r   [PAT_MAX];
  logic [7:0]                       hist_nxt [PAT_MAX];
  logic [OFFSET_BITS-1:0]           pos_r, pos_nxt, pos_cur;
  logic [mbps_pkg::COUNT_W-1:0]     count_r, count_nxt, count_cur;
  logic                             stopped_r, stopped_nxt, stop_pre;

  // Output buffer
  mbps_pkg::result_t                out_r, out_nxt, skid_r, skid_nxt, res;
  logic                             out_valid_r, out_valid_nxt, skid_valid_r, skid_valid_nxt;

  logic                             in_acc, pop;
  logic [mbps_pkg::LEN_W-1:0]       len_eff, len_m1;
  logic [PAT_BYTES_ALL_W-1:0]       pat_all;
  logic [PAT_MAX-1:0]               byte_ok;
  logic                             window_full, hit;
  logic [OFFSET_BITS-1:0]           offset;

  assign in_acc         = in_beat.valid && in_beat.ready;
  assign pop            = out_valid_r && out_beat.ready;
  assign in_beat.ready  = !skid_valid_r;
  assign cfg_beat.ready = 1'b1;

  assign out_beat.valid         = out_valid_r;
  assign out_beat.match_found   = out_r.match_found;
  assign out_beat.match_offset  = out_r.match_offset;
  assign out_beat.limit_reached = out_r.limit_reached;
  assign out_beat.scan_done     = out_r.scan_done;

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_high_r <= '0;
      care_r     <= '0;
      len_r      <= mbps_pkg::LEN_W'(1);
      limit_r    <= '0;
    end else if (cfg_beat.valid && cfg_beat.ready) begin
      unique case (mbps_pkg::cfg_idx_t'(cfg_beat.reg_index))
        mbps_pkg::CFG_PAT_LOW:  pat_low_r  <= cfg_beat.wr_data;
        mbps_pkg::CFG_PAT_HIGH: pat_high_r <= cfg_beat.wr_data;
        mbps_pkg::CFG_CARE:     care_r     <= cfg_beat.wr_data[mbps_pkg::CARE_W-1:0];
        mbps_pkg::CFG_LENGTH:   len_r      <= cfg_beat.wr_data[mbps_pkg::LEN_W-1:0];
        mbps_pkg::CFG_LIMIT:    limit_r    <= cfg_beat.wr_data[mbps_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective pattern length, clamped to 1..PAT_MAX
  always_comb begin
    if (len_r == '0)
      len_eff = mbps_pkg::LEN_W'(1);
    else if (len_r > PAT_MAX_L)
      len_eff = PAT_MAX_L;
    else
      len_eff = len_r;
    len_m1 = len_eff - mbps_pkg::LEN_W'(1);
  end

  assign pat_all = {pat_high_r, pat_low_r};

  // History shift; region start clears the older entries
  always_comb begin
    hist_nxt[0] = in_beat.data_byte;
    for (int k = 1; k < PAT_MAX; k++)
      hist_nxt[k] = in_beat.region_start ? 8'h00 : hist_r[k-1];
  end

  // Per-byte masked compare; pattern byte i meets history entry len-1-i
  always_comb begin
    logic [mbps_pkg::LEN_W-1:0] idx;
    for (int i = 0; i < PAT_MAX; i++) begin
      idx = (len_m1 - mbps_pkg::LEN_W'(i)) & IDX_MASK;
      byte_ok[i] = !care_r[i] || (mbps_pkg::LEN_W'(i) >= len_eff) ||
                   (pat_all[8*i +: 8] == hist_nxt[idx[IDX_W-1:0]]);
    end
  end

  // Position, count and stop logic
  always_comb begin
    pos_cur     = in_beat.region_start ? '0 : pos_r;
    count_cur   = in_beat.region_start ? '0 : count_r;
    stop_pre    = !in_beat.region_start && stopped_r;
    pos_nxt     = (pos_cur != '1) ? pos_cur + OFFSET_BITS'(1) : pos_cur;
    stop_pre    = stop_pre || ((limit_r != '0) && (count_cur >= limit_r));
    window_full = pos_cur >= OFFSET_BITS'(len_m1);
    hit         = window_full && !stop_pre && (&byte_ok);
    offset      = hit ? pos_cur - OFFSET_BITS'(len_m1) : '0;
    count_nxt   = (hit && (count_cur != '1)) ? count_cur + mbps_pkg::COUNT_W'(1) : count_cur;
    stopped_nxt = stop_pre || (hit && (limit_r != '0) && (count_nxt >= limit_r));

    res.match_found   = hit;
    res.match_offset  = mbps_pkg::OUT_OFF_W'(offset);
    res.limit_reached = stopped_nxt;
    res.scan_done     = in_beat.region_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < PAT_MAX; k++)
        hist_r[k] <= 8'h00;
      pos_r     <= '0;
      count_r   <= '0;
      stopped_r <= 1'b0;
    end else if (in_acc) begin
      hist_r    <= hist_nxt;
      pos_r     <= pos_nxt;
      count_r   <= count_nxt;
      stopped_r <= stopped_nxt;
    end
  end

  // Result register plus skid entry
  always_comb begin
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (skid_valid_r) begin
      if (pop) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (in_acc) begin
      if (!out_valid_r || pop) begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = res;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  // Checks
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without a result in the output register");

  a_start_restarts_pos: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_beat.region_start |=> pos_r == OFFSET_BITS'(1))
    else $error("region start did not restart the byte position");

  a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r && !(in_acc && in_beat.region_start) |=> stopped_r)
    else $error("stop flag dropped without a region start");

  a_stop_has_count: assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r |-> count_r != '0)
    else $error("scan stopped with zero matches counted");

endmodule

// ===== sim/tb_masked_byte_pattern_scanner_unit.sv =====
`timescale 1ns / 1ps

module tb_masked_byte_pattern_scanner_unit;

  // One byte of the scanned stream
  typedef struct packed {
    logic [7:0] data_byte;
    logic       region_start;
    logic       region_end;
  } scan_item_t;

  logic clk;
  logic rst_n;

  mbps_in_if  in_bus ();
  mbps_out_if out_bus ();
  mbps_cfg_if cfg_bus ();

  masked_byte_pattern_scanner_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_beat  (in_bus),
    .out_beat (out_bus),
    .cfg_beat (cfg_bus)
  );

  // Clock: 4 ns period
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Register shadow
  logic [63:0]                  pat_lo_cfg;
  logic [63:0]                  pat_hi_cfg;
  logic [mbps_pkg::CARE_W-1:0]  care_cfg;
  logic [mbps_pkg::LEN_W-1:0]   len_cfg;
  logic [mbps_pkg::LIMIT_W-1:0] limit_cfg;

  // Scanner state mirror
  logic [7:0]                   recent_bytes [mbps_pkg::PAT_BYTES_MAX];
  logic [31:0]                  byte_pos;
  logic [mbps_pkg::COUNT_W-1:0] hit_count;
  logic                         hits_capped;

  // Bytes waiting to go in, results still owed by the block
  scan_item_t        byte_stream [$];
  mbps_pkg::result_t window_reports [$];

  // Flow control knobs, written by the sequencer at clock edges
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  logic        send_hold;
  logic        hold_kick;
  int unsigned hold_left;

  int unsigned bytes_queued;
  int unsigned bytes_sent;
  int unsigned reports_seen;
  int unsigned hits_seen;
  int unsigned capped_seen;
  int unsigned setups_done;
  int unsigned err_count;

  // Shift one byte into the window and work out its result beat
  function automatic mbps_pkg::result_t scan_byte(scan_item_t it);
    int unsigned       wlen;
    logic [31:0]       pos;
    logic [127:0]      pat_all;
    logic              all_ok;
    mbps_pkg::result_t res;
    pat_all = {pat_hi_cfg, pat_lo_cfg};
    res = '0;
    if (it.region_start) begin
      foreach (recent_bytes[k]) recent_bytes[k] = 8'h00;
      byte_pos = '0;
      hit_count = '0;
      hits_capped = 1'b0;
    end
    // length zero acts as one, anything past the window size as the full window
    wlen = (len_cfg == 0) ? 1 :
           (len_cfg > mbps_pkg::PAT_BYTES_MAX) ? mbps_pkg::PAT_BYTES_MAX : len_cfg;
    for (int k = mbps_pkg::PAT_BYTES_MAX - 1; k > 0; k--) recent_bytes[k] = recent_bytes[k-1];
    recent_bytes[0] = it.data_byte;
    pos = byte_pos;
    if (byte_pos != '1) byte_pos = byte_pos + 32'd1;
    if (limit_cfg != 0 && hit_count >= limit_cfg) hits_capped = 1'b1;
    if (pos >= wlen - 1 && !hits_capped) begin
      all_ok = 1'b1;
      for (int i = 0; i < wlen; i++) begin
        if (care_cfg[i] && pat_all[8*i +: 8] != recent_bytes[wlen-1-i]) all_ok = 1'b0;
      end
      if (all_ok) begin
        res.match_found = 1'b1;
        res.match_offset = pos - (wlen - 1);
        if (hit_count != '1) hit_count = hit_count + mbps_pkg::COUNT_W'(1);
        if (limit_cfg != 0 && hit_count >= limit_cfg) hits_capped = 1'b1;
      end
    end
    res.limit_reached = hits_capped;
    res.scan_done = it.region_end;
    return res;
  endfunction

  // Input driver: holds a beat until taken, idles only between beats
  always @(posedge clk) begin : drive_in
    scan_item_t taken;
    logic       busy;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      busy = in_bus.valid;
      if (in_bus.valid && in_bus.ready) begin
        taken = byte_stream.pop_front();
        window_reports = {window_reports, scan_byte(taken)};
        bytes_sent++;
        busy = 1'b0;
      end
      if (!busy) begin
        if (byte_stream.size() != 0 && !send_hold &&
            $urandom_range(99) >= send_idle_pct) begin
          in_bus.valid        <= 1'b1;
          in_bus.data_byte    <= byte_stream[0].data_byte;
          in_bus.region_start <= byte_stream[0].region_start;
          in_bus.region_end   <= byte_stream[0].region_end;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_kick && hold_left == 0) begin
      hold_left <= 300;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result monitor: checks each beat against the oldest owed result
  always @(posedge clk) begin : watch_out
    mbps_pkg::result_t got;
    mbps_pkg::result_t want;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        got.match_found   = out_bus.match_found;
        got.match_offset  = out_bus.match_offset;
        got.limit_reached = out_bus.limit_reached;
        got.scan_done     = out_bus.scan_done;
        reports_seen++;
        if (got.match_found) hits_seen++;
        if (got.limit_reached) capped_seen++;
        if (window_reports.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result beat found=%b off=%0d lim=%b done=%b",
                   $time, got.match_found, got.match_offset, got.limit_reached,
                   got.scan_done);
        end else begin
          want = window_reports.pop_front();
          if (got !== want) begin
            err_count++;
            $display("%0t: beat %0d expected found=%b off=%0d lim=%b done=%b",
                     $time, reports_seen, want.match_found, want.match_offset,
                     want.limit_reached, want.scan_done);
            $display("%0t: beat %0d actual   found=%b off=%0d lim=%b done=%b",
                     $time, reports_seen, got.match_found, got.match_offset,
                     got.limit_reached, got.scan_done);
          end
        end
      end
      out_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic push_byte(logic [7:0] data, logic first, logic last);
    scan_item_t it;
    it.data_byte = data;
    it.region_start = first;
    it.region_end = last;
    byte_stream = {byte_stream, it};
    bytes_queued++;
  endtask

  // Wait until the block has nothing in flight; returns at a rising edge
  task automatic drain();
    do @(negedge clk);
    while (byte_stream.size() != 0 || in_bus.valid || window_reports.size() != 0);
    @(posedge clk);
  endtask

  // Write all five registers back to back; call at a rising edge with the block idle
  task automatic load_setup(logic [63:0] lo, logic [63:0] hi, logic [63:0] care_w,
                            logic [63:0] len_w, logic [63:0] lim_w);
    mbps_pkg::cfg_idx_t regs [5];
    logic [63:0]        vals [5];
    regs = '{mbps_pkg::CFG_PAT_LOW, mbps_pkg::CFG_PAT_HIGH, mbps_pkg::CFG_CARE,
             mbps_pkg::CFG_LENGTH, mbps_pkg::CFG_LIMIT};
    vals = '{lo, hi, care_w, len_w, lim_w};
    for (int i = 0; i < 5; i++) begin
      cfg_bus.valid     <= 1'b1;
      cfg_bus.reg_index <= regs[i];
      cfg_bus.wr_data   <= vals[i];
      do @(posedge clk);
      while (!cfg_bus.ready);
      case (regs[i])
        mbps_pkg::CFG_PAT_LOW:  pat_lo_cfg = vals[i];
        mbps_pkg::CFG_PAT_HIGH: pat_hi_cfg = vals[i];
        mbps_pkg::CFG_CARE:     care_cfg   = vals[i][mbps_pkg::CARE_W-1:0];
        mbps_pkg::CFG_LENGTH:   len_cfg    = vals[i][mbps_pkg::LEN_W-1:0];
        mbps_pkg::CFG_LIMIT:    limit_cfg  = vals[i][mbps_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
    cfg_bus.valid <= 1'b0;
    setups_done++;
  endtask

  // Queue one region, rich in planted pattern copies; some flags get scrambled
  task automatic add_region(int unsigned n, logic first, logic last);
    logic [7:0]   body [$];
    logic [127:0] pat_all;
    int unsigned  wlen;
    int unsigned  r;
    logic         s_flag;
    logic         e_flag;
    pat_all = {pat_hi_cfg, pat_lo_cfg};
    wlen = (len_cfg == 0) ? 1 :
           (len_cfg > mbps_pkg::PAT_BYTES_MAX) ? mbps_pkg::PAT_BYTES_MAX : len_cfg;
    while (body.size() < n) begin
      r = $urandom_range(99);
      if (r < 35) begin
        for (int i = 0; i < wlen; i++)
          body = {body, (care_cfg[i] ? pat_all[8*i +: 8] : 8'($urandom))};
      end else if (r < 75) begin
        body = {body, pat_all[8*$urandom_range(wlen-1) +: 8]};
      end else begin
        body = {body, 8'($urandom)};
      end
    end
    foreach (body[i]) begin
      s_flag = (i == 0) && first;
      e_flag = (i == body.size() - 1) && last;
      if ($urandom_range(99) < 3) s_flag = 1'($urandom);
      if ($urandom_range(99) < 3) e_flag = 1'($urandom);
      push_byte(body[i], s_flag, e_flag);
    end
  endtask

  // Sequencer
  initial begin : sequencer
    int unsigned mode;
    int unsigned target;
    int unsigned r;
    int unsigned len_v;
    logic [63:0] lo_w, hi_w, care_w, len_w, lim_w;
    logic        first_open;

    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.data_byte = 8'h00;
    in_bus.region_start = 1'b0;
    in_bus.region_end = 1'b0;
    out_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.reg_index = mbps_pkg::CFG_PAT_LOW;
    cfg_bus.wr_data = '0;
    send_idle_pct = 0;
    stall_pct = 0;
    send_hold = 1'b0;
    hold_kick = 1'b0;
    bytes_queued = 0;
    bytes_sent = 0;
    reports_seen = 0;
    hits_seen = 0;
    capped_seen = 0;
    setups_done = 0;
    err_count = 0;
    pat_lo_cfg = '0;
    pat_hi_cfg = '0;
    care_cfg = '0;
    len_cfg = mbps_pkg::LEN_W'(1);
    limit_cfg = '0;
    foreach (recent_bytes[k]) recent_bytes[k] = 8'h00;
    byte_pos = '0;
    hit_count = '0;
    hits_capped = 1'b0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults: one-byte pattern, no care bits, so every byte matches
    push_byte(8'h00, 1'b1, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b0);
    push_byte(8'h5A, 1'b0, 1'b1);
    push_byte(8'h80, 1'b1, 1'b1);   // region of a single byte
    drain();

    // "AB?D" with a wildcard in byte 2; care bits past the length are set
    load_setup(64'hA5A5_A5A5_443F_4241, '1, 64'hFFFF_FFFF_FFFF_FFFB, 64'd4, 64'd0);
    push_byte("A", 1'b1, 1'b0);
    push_byte("B", 1'b0, 1'b0);
    push_byte("Z", 1'b0, 1'b0);
    push_byte("D", 1'b0, 1'b0);
    push_byte("A", 1'b0, 1'b0);
    push_byte("B", 1'b0, 1'b0);
    push_byte("C", 1'b0, 1'b0);
    push_byte("D", 1'b0, 1'b0);
    push_byte("A", 1'b0, 1'b0);
    push_byte("B", 1'b0, 1'b0);
    // history would match, but the new region has too few bytes
    push_byte("Z", 1'b1, 1'b0);
    push_byte("D", 1'b0, 1'b1);
    drain();

    // zero length behaves as one
    load_setup(64'hFF, 64'h0, 64'h1, 64'd0, 64'd0);
    push_byte(8'hFF, 1'b1, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b1);
    drain();

    // limit of two on an always-matching pattern
    load_setup(64'h0, 64'h0, 64'h0, 64'd1, 64'd2);
    push_byte(8'h11, 1'b1, 1'b0);
    push_byte(8'h22, 1'b0, 1'b0);
    push_byte(8'h33, 1'b0, 1'b0);
    push_byte(8'h44, 1'b0, 1'b1);
    drain();

    // Random phases; settings change between them, often mid-region
    for (int ph = 0; bytes_queued < 1500 || ph < 12; ph++) begin
      mode = ph % 4;
      send_idle_pct <= (ph == 5) ? 0 : (mode == 1) ? 74 : (mode == 3) ? 19 : 0;
      stall_pct     <= (ph == 5) ? 0 : (mode == 2) ? 74 : (mode == 3) ? 19 : 0;

      r = $urandom_range(99);
      len_v = (r < 5) ? 0 : (r < 70) ? $urandom_range(6, 1) :
              (r < 88) ? $urandom_range(16, 7) : $urandom_range(31, 17);
      r = $urandom_range(99);
      lo_w = {$urandom, $urandom};
      hi_w = {$urandom, $urandom};
      if (r < 10) begin
        lo_w = '0;
        hi_w = '0;
      end else if (r < 20) begin
        lo_w = '1;
        hi_w = '1;
      end
      care_w = {$urandom, $urandom};
      r = $urandom_range(99);
      if (r < 20) care_w[mbps_pkg::CARE_W-1:0] = '0;
      else if (r < 40) care_w[mbps_pkg::CARE_W-1:0] = '1;
      len_w = {$urandom, $urandom};
      len_w[mbps_pkg::LEN_W-1:0] = mbps_pkg::LEN_W'(len_v);
      lim_w = {$urandom, $urandom};
      r = $urandom_range(99);
      lim_w[mbps_pkg::LIMIT_W-1:0] = mbps_pkg::LIMIT_W'((r < 50) ? 0 :
                                     (r < 80) ? $urandom_range(4, 1) :
                                     (r < 95) ? $urandom_range(40, 5) : 16'hFFFF);
      load_setup(lo_w, hi_w, care_w, len_w, lim_w);

      @(negedge clk);
      target = (ph == 5 || ph == 9) ? 150 : $urandom_range(140, 60);
      first_open = ($urandom_range(1) == 1);
      while (byte_stream.size() < target) begin
        add_region(($urandom_range(19) == 0) ? $urandom_range(300, 150) :
                   $urandom_range(40, 1),
                   first_open, $urandom_range(9) != 0);
        first_open = ($urandom_range(9) != 0);
      end
      @(posedge clk);

      if (ph == 5) begin
        // receiver goes quiet while the sender keeps pushing
        hold_kick <= 1'b1;
        @(posedge clk);
        hold_kick <= 1'b0;
      end
      if (ph == 9) begin
        // sender stops mid-stream until the block has emptied out
        while (byte_stream.size() > target / 2) @(negedge clk);
        @(posedge clk);
        send_hold <= 1'b1;
        do @(negedge clk);
        while (in_bus.valid || window_reports.size() != 0);
        @(posedge clk);
        send_hold <= 1'b0;
      end
      drain();
    end

    // let any stray beat show up
    repeat (10) @(posedge clk);
    if (window_reports.size() != 0) begin
      err_count++;
      $display("%0t: %0d result beats never arrived", $time, window_reports.size());
    end

    $display("run: %0d bytes scanned under %0d register setups, %0d result beats",
             bytes_sent, setups_done, reports_seen);
    $display("run: %0d matches reported, %0d beats with the match limit in force",
             hits_seen, capped_seen);
    if (err_count == 0) begin
      $display("tb_masked_byte_pattern_scanner_unit: clean");
    end else begin
      $display("tb_masked_byte_pattern_scanner_unit: errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("%0t: timeout with %0d bytes queued, %0d results owed", $time,
             byte_stream.size(), window_reports.size());
    $display("tb_masked_byte_pattern_scanner_unit: errors");
    $finish;
  end

endmodule
